// ----- design/gtfc_pkg.sv -----
// Shared widths, write-source codes and the controller-to-datapath command word.
package gtfc_pkg;

   // Field widths fixed by the interface
   localparam int ROW_W = 32;
   localparam int CNT_W = 6;
   localparam int IDX_W = 5;

   // Source of the word written into the row store
   typedef enum logic [1:0] {
      WR_LOAD = 2'd0,   // incoming row from the request channel
      WR_PREP = 2'd1,   // masked copy of a stored row, or zero
      WR_EDGE = 2'd2,   // row v with bit u added
      WR_BACK = 2'd3    // current row u written back
   } wr_src_type;

   // Command word from the controller
   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      wr_src_type         wr_src;
      logic [IDX_W-1:0]   u;
      logic [IDX_W-1:0]   v;
      logic               load_cur;
      logic               decide;
      logic               emit_issue;
      logic               emit_last;
      logic [CNT_W-1:0]   n;
      logic [CNT_W-1:0]   rows_loaded;
   } cmd_type;

endpackage

// ----- design/greedy_triangle_free_completion.sv -----
// Greedy triangle-free completion: rows load one per cycle; after the last row a clean-up sweep
// runs, then the pair scan (one pair per cycle through the single-write row store), and the
// completed rows then leave one per cycle while the sink is ready. Synchronous active-high
// reset returns to loading with no rows held. Top level: joins the controller and the datapath.
module greedy_triangle_free_completion #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [gtfc_pkg::ROW_W-1:0] req_row_bits,
   input  logic [gtfc_pkg::CNT_W-1:0] req_vertex_count,
   input  logic                       req_last_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [gtfc_pkg::IDX_W-1:0] rsp_vertex_index,
   output logic [gtfc_pkg::ROW_W-1:0] rsp_completed_row,
   output logic                       rsp_final_row
);

   gtfc_pkg::cmd_type cmd;
   logic              add_edge;

   gtfc_ctrl #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vertex_count (req_vertex_count),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .add_edge         (add_edge),
      .cmd              (cmd)
   );

   gtfc_datapath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_row_bits      (req_row_bits),
      .add_edge          (add_edge),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_completed_row (rsp_completed_row),
      .rsp_final_row     (rsp_final_row)
   );

endmodule

// ----- design/gtfc_datapath.sv -----
// Row store, current-row register, pair test and result payload registers.
module gtfc_datapath #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                       clock,
   input  gtfc_pkg::cmd_type          cmd,
   input  logic [gtfc_pkg::ROW_W-1:0] req_row_bits,
   output logic                       add_edge,
   output logic [gtfc_pkg::IDX_W-1:0] rsp_vertex_index,
   output logic [gtfc_pkg::ROW_W-1:0] rsp_completed_row,
   output logic                       rsp_final_row
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   logic [gtfc_pkg::ROW_W-1:0] mem [MAX_VERTICES];
   logic [gtfc_pkg::ROW_W-1:0] rd_data_ff;
   logic [gtfc_pkg::ROW_W-1:0] cur_u_ff, cur_u_in;
   logic [gtfc_pkg::IDX_W-1:0] idx_ff;
   logic                       final_ff;
   logic [gtfc_pkg::ROW_W-1:0] mask;
   logic [gtfc_pkg::ROW_W-1:0] u_bit, v_bit;
   logic [gtfc_pkg::ROW_W-1:0] wr_data;

   // Column mask: bits at or above the vertex count are cleared
   always_comb begin
      for (int j = 0; j < gtfc_pkg::ROW_W; j++) begin
         mask[j] = (gtfc_pkg::CNT_W'(j) < cmd.n);
      end
   end

   assign u_bit = gtfc_pkg::ROW_W'(1) << cmd.u;
   assign v_bit = gtfc_pkg::ROW_W'(1) << cmd.v;

   // Pair test: no edge u-v yet and no common neighbour
   assign add_edge = !cur_u_ff[cmd.v] && ((cur_u_ff & rd_data_ff) == '0);

   // Write word select
   always_comb begin
      case (cmd.wr_src)
         gtfc_pkg::WR_LOAD: wr_data = req_row_bits;
         gtfc_pkg::WR_PREP: begin
            if ({1'b0, cmd.wr_addr} < cmd.rows_loaded) wr_data = rd_data_ff & mask;
            else wr_data = '0;
         end
         gtfc_pkg::WR_EDGE: wr_data = rd_data_ff | u_bit;
         gtfc_pkg::WR_BACK: wr_data = cur_u_ff;
         default:           wr_data = '0;
      endcase
   end

   // Row store with registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   // Current row u: loaded at the head of each sweep, grows as edges are added
   always_comb begin
      cur_u_in = cur_u_ff;
      if (cmd.load_cur) cur_u_in = rd_data_ff;
      else if (cmd.decide && add_edge) cur_u_in = cur_u_ff | v_bit;
   end

   always_ff @(posedge clock) begin
      cur_u_ff <= cur_u_in;
      if (cmd.emit_issue) begin
         idx_ff   <= cmd.rd_addr;
         final_ff <= cmd.emit_last;
      end
   end

   assign rsp_vertex_index  = idx_ff;
   assign rsp_completed_row = rd_data_ff;
   assign rsp_final_row     = final_ff;

endmodule

// ----- design/gtfc_ctrl.sv -----
// Controller: load, row clean-up sweep, ordered pair scan and row emission.
module gtfc_ctrl #(
   parameter int MAX_VERTICES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [gtfc_pkg::CNT_W-1:0] req_vertex_count,
   input  logic                       req_last_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       add_edge,
   output gtfc_pkg::cmd_type          cmd
);

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_PREP = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam logic [gtfc_pkg::CNT_W-1:0] MAX_CNT = gtfc_pkg::CNT_W'(MAX_VERTICES);

   state_type                  state_ff, state_in;
   logic [gtfc_pkg::CNT_W-1:0] n_ff, n_in;
   logic [gtfc_pkg::CNT_W-1:0] rows_ff, rows_in;
   logic [gtfc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [gtfc_pkg::IDX_W-1:0] u_ff, u_in;
   logic [gtfc_pkg::IDX_W-1:0] v_ff, v_in;
   logic                       head_ff, head_in;
   logic                       valid_ff, valid_in;
   logic [gtfc_pkg::CNT_W-1:0] n_last;
   logic                       u_is_last, v_is_last, emit_go;

   assign n_last    = n_ff - gtfc_pkg::CNT_W'(1);
   assign u_is_last = ({1'b0, u_ff} == n_last);
   assign v_is_last = ({1'b0, v_ff} == n_last);
   assign emit_go   = (!valid_ff || rsp_ready) && (cnt_ff < n_ff);

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = valid_ff;

   // Next state and command word
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      rows_in  = rows_ff;
      cnt_in   = cnt_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      head_in  = head_ff;
      valid_in = valid_ff;

      cmd             = '0;
      cmd.wr_src      = gtfc_pkg::WR_LOAD;
      cmd.u           = u_ff;
      cmd.v           = v_ff;
      cmd.n           = n_ff;
      cmd.rows_loaded = rows_ff;

      case (state_ff)
         // Store incoming rows, latch the clamped vertex count
         ST_LOAD: begin
            if (req_valid) begin
               if (req_vertex_count == '0) n_in = gtfc_pkg::CNT_W'(1);
               else if (req_vertex_count > MAX_CNT) n_in = MAX_CNT;
               else n_in = req_vertex_count;
               if (rows_ff < MAX_CNT) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = rows_ff[gtfc_pkg::IDX_W-1:0];
                  cmd.wr_src  = gtfc_pkg::WR_LOAD;
                  rows_in     = rows_ff + gtfc_pkg::CNT_W'(1);
               end
               if (req_last_row) begin
                  state_in = ST_PREP;
                  cnt_in   = '0;
               end
            end
         end

         // Read row c, write back the masked row c-1; last step fetches row 0
         ST_PREP: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff < n_ff) cmd.rd_addr = cnt_ff[gtfc_pkg::IDX_W-1:0];
            else cmd.rd_addr = '0;
            if (cnt_ff != '0) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = gtfc_pkg::IDX_W'(cnt_ff - gtfc_pkg::CNT_W'(1));
               cmd.wr_src  = gtfc_pkg::WR_PREP;
            end
            if (cnt_ff == n_ff) begin
               state_in = ST_SCAN;
               u_in     = '0;
               head_in  = 1'b1;
            end else begin
               cnt_in = cnt_ff + gtfc_pkg::CNT_W'(1);
            end
         end

         // Pair scan: head step loads row u, then one pair (u, v) per cycle
         ST_SCAN: begin
            if (head_ff) begin
               cmd.load_cur = 1'b1;
               if (u_ff != '0) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = u_ff - gtfc_pkg::IDX_W'(1);
                  cmd.wr_src  = gtfc_pkg::WR_BACK;
               end
               if (u_is_last) begin
                  state_in = ST_EMIT;
                  cnt_in   = '0;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = u_ff + gtfc_pkg::IDX_W'(1);
                  v_in        = u_ff + gtfc_pkg::IDX_W'(1);
                  head_in     = 1'b0;
               end
            end else begin
               cmd.decide  = 1'b1;
               cmd.wr_en   = add_edge;
               cmd.wr_addr = v_ff;
               cmd.wr_src  = gtfc_pkg::WR_EDGE;
               cmd.rd_en   = 1'b1;
               if (v_is_last) begin
                  cmd.rd_addr = u_ff + gtfc_pkg::IDX_W'(1);
                  u_in        = u_ff + gtfc_pkg::IDX_W'(1);
                  head_in     = 1'b1;
               end else begin
                  cmd.rd_addr = v_ff + gtfc_pkg::IDX_W'(1);
                  v_in        = v_ff + gtfc_pkg::IDX_W'(1);
               end
            end
         end

         // Emit rows in order, one per cycle while the sink takes them
         ST_EMIT: begin
            if (emit_go) begin
               cmd.rd_en      = 1'b1;
               cmd.rd_addr    = cnt_ff[gtfc_pkg::IDX_W-1:0];
               cmd.emit_issue = 1'b1;
               cmd.emit_last  = (cnt_ff == n_last);
               cnt_in         = cnt_ff + gtfc_pkg::CNT_W'(1);
               valid_in       = 1'b1;
            end else if (valid_ff && rsp_ready) begin
               valid_in = 1'b0;
               if (cnt_ff == n_ff) begin
                  state_in = ST_LOAD;
                  rows_in  = '0;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff     <= '0;
         rows_ff  <= '0;
         cnt_ff   <= '0;
         u_ff     <= '0;
         v_ff     <= '0;
         head_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         rows_ff  <= rows_in;
         cnt_ff   <= cnt_in;
         u_ff     <= u_in;
         v_ff     <= v_in;
         head_ff  <= head_in;
         valid_ff <= valid_in;
      end
   end

endmodule
